FILE: hdl/sal_pkg.sv
// shared types and operation codes for the sequential array list
package sal_pkg;
   localparam logic [3:0] OP_INS_FRONT = 4'd0;
   localparam logic [3:0] OP_INS_END   = 4'd1;
   localparam logic [3:0] OP_INS_SORT  = 4'd2;
   localparam logic [3:0] OP_INS_AT    = 4'd3;
   localparam logic [3:0] OP_RM_FRONT  = 4'd4;
   localparam logic [3:0] OP_RM_END    = 4'd5;
   localparam logic [3:0] OP_RM_AT     = 4'd6;
   localparam logic [3:0] OP_FIND      = 4'd7;
   localparam logic [3:0] OP_READ      = 4'd8;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic shift_step;
      logic write_new;
      logic count_up;
      logic count_down;
      logic set_found;
      logic set_fail;
   } sal_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic scan_hit;
      logic shift_done;
      logic full;
      logic empty;
      logic pos_ok_ins;
      logic pos_ok_rm;
   } sal_stat_type;
endpackage

FILE: hdl/sal_ram.sv
// generic simple dual port ram (separate write and read addresses) with registered read
module sal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hdl/sal_datapath.sv
// record storage, scan and shift datapath
module sal_datapath #(
   parameter int CAPACITY     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sal_pkg::sal_cmd_type       cmd,
   output sal_pkg::sal_stat_type      stat,
   input  logic [3:0]                 req_operation,
   input  logic [5:0]                 req_position,
   input  logic signed [31:0]         req_entry_key,
   input  logic [31:0]                req_entry_payload,
   output logic signed [31:0]         res_key,
   output logic [31:0]                res_payload,
   output logic [4:0]                 res_position,
   output logic [5:0]                 res_count,
   output logic                       res_full,
   output logic                       res_empty
);
   import sal_pkg::*;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = $clog2(CAPACITY + 64);

   logic [CW-1:0] count_ff, count_in;
   logic [3:0] op_ff;
   logic [PW-1:0] pos_ff;
   logic signed [31:0] key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [CW-1:0] idx_ff, idx_in;   // scan / shift index
   logic [CW-1:0] tgt_ff, tgt_in;   // target position
   logic [CW-1:0] tgt_sel;
   logic pend_ff, pend_in;          // ram read valid for idx_ff-1 at scan
   logic sh_ph_ff, sh_ph_in;        // shift phase: 0 read, 1 write
   logic signed [31:0] res_key_ff;
   logic [31:0] res_payload_ff;
   logic [4:0] res_position_ff;
   logic [5:0] res_count_ff;
   logic res_full_ff, res_empty_ff;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_key, rd_key;
   logic [PAYLOAD_BITS-1:0] wr_pay, rd_pay;
   logic is_ins;
   logic scans;
   logic in_range;
   logic [PW-1:0] cnt_w;
   logic signed [31:0] rk;

   sal_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_key),
      .rd_addr(rd_addr), .rd_data(rd_key));
   sal_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_pays (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_pay),
      .rd_addr(rd_addr), .rd_data(rd_pay));

   assign is_ins = (op_ff <= OP_INS_AT);
   assign scans = (op_ff == OP_FIND) || (op_ff == OP_INS_SORT);

   assign cnt_w = PW'(count_ff);
   assign stat.full = (count_ff == CW'(CAPACITY));
   assign stat.empty = (count_ff == '0);
   assign stat.pos_ok_ins = (pos_ff <= cnt_w);
   assign stat.pos_ok_rm = (pos_ff < cnt_w);
   // scan: read address idx, data arrives next cycle for idx-1
   assign rk = $signed(rd_key);
   assign in_range = (idx_ff <= count_ff);
   assign stat.scan_hit = pend_ff && in_range
                          && ((op_ff == OP_FIND) ? (rk == key_ff) : (rk > key_ff));
   assign stat.scan_done = !scans || stat.scan_hit || (!pend_ff && idx_ff >= count_ff)
                           || (pend_ff && idx_ff > count_ff);
   // shift done when no moves remain
   assign stat.shift_done = is_ins ? (idx_ff <= tgt_ff) : (idx_ff + 1'b1 >= count_ff);

   always_comb begin
      case (op_ff)
         OP_INS_FRONT, OP_RM_FRONT: tgt_sel = '0;
         OP_INS_END:  tgt_sel = count_ff;
         OP_INS_SORT: tgt_sel = stat.scan_hit ? CW'(idx_ff - 1'b1) : count_ff;
         OP_RM_END:   tgt_sel = count_ff - 1'b1;
         default:     tgt_sel = CW'(pos_ff);
      endcase
   end

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_key = rd_key;
      wr_pay = rd_pay;
      if (cmd.scan_step && !scans) rd_addr = pos_ff[AW-1:0];
      if (cmd.shift_step) begin
         if (is_ins) rd_addr = AW'(idx_ff - 1'b1);
         else rd_addr = AW'(idx_ff + 1'b1);
         wr_en = sh_ph_ff;
      end
      if (cmd.write_new) begin
         wr_en = 1'b1;
         wr_addr = tgt_ff[AW-1:0];
         wr_key = key_ff;
         wr_pay = pay_ff;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      tgt_in = tgt_ff;
      pend_in = cmd.scan_step && !stat.scan_done;
      sh_ph_in = cmd.shift_step && !sh_ph_ff;
      count_in = count_ff;
      if (cmd.count_up) count_in = count_ff + 1'b1;
      else if (cmd.count_down) count_in = count_ff - 1'b1;
      if (cmd.load) idx_in = '0;
      if (cmd.scan_step) begin
         if (stat.scan_done) begin
            tgt_in = tgt_sel;
            idx_in = is_ins ? count_ff : tgt_sel;
         end else idx_in = idx_ff + 1'b1;
      end
      if (cmd.shift_step && sh_ph_ff) idx_in = is_ins ? idx_ff - 1'b1 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff <= 1'b0;
         sh_ph_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff <= pend_in;
         sh_ph_ff <= sh_ph_in;
      end
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      if (cmd.load) begin
         op_ff <= req_operation;
         pos_ff <= PW'(req_position);
         key_ff <= req_entry_key;
         pay_ff <= PAYLOAD_BITS'(req_entry_payload);
      end
      if (cmd.set_found) begin
         res_key_ff <= rk;
         res_payload_ff <= 32'(rd_pay);
         res_position_ff <= (op_ff == OP_FIND) ? 5'(idx_ff - 1'b1) : 5'(tgt_ff);
      end else if (cmd.set_fail) begin
         res_key_ff <= '0;
         res_payload_ff <= '0;
         res_position_ff <= '0;
      end
      res_count_ff <= 6'(count_ff);
      res_full_ff <= stat.full;
      res_empty_ff <= stat.empty;
   end

   assign res_key = res_key_ff;
   assign res_payload = res_payload_ff;
   assign res_position = res_position_ff;
   assign res_count = res_count_ff;
   assign res_full = res_full_ff;
   assign res_empty = res_empty_ff;
endmodule

FILE: hdl/sal_control.sv
// operation sequencer for the sequential array list
module sal_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_operation,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sal_pkg::sal_cmd_type  cmd,
   input  sal_pkg::sal_stat_type stat,
   output logic                  mode_ok
);
   import sal_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_SCAN = 3'd2,
                          S_SHIFT = 3'd3, S_WRITE = 3'd4, S_COUNT = 3'd5,
                          S_RESULT = 3'd6, S_DONE = 3'd7;
   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff;
   logic ok_ff, ok_in;
   logic is_ins;
   assign is_ins = (op_ff <= OP_INS_AT);
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign mode_ok = ok_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      ok_in = ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ok_in = 1'b0;
            state_in = S_COUNT;
            case (op_ff)
               OP_INS_FRONT, OP_INS_END, OP_INS_AT:
                  if (!stat.full && (op_ff != OP_INS_AT || stat.pos_ok_ins)) begin
                     ok_in = 1'b1;
                     state_in = S_SCAN;
                  end
               OP_INS_SORT:
                  if (!stat.full) begin
                     ok_in = 1'b1;
                     state_in = S_SCAN;
                  end
               OP_RM_FRONT, OP_RM_END, OP_RM_AT:
                  if (!stat.empty && (op_ff != OP_RM_AT || stat.pos_ok_rm)) begin
                     ok_in = 1'b1;
                     state_in = S_SCAN;
                  end
               OP_FIND: begin
                  ok_in = 1'b1;
                  state_in = S_SCAN;
               end
               OP_READ:
                  if (stat.pos_ok_rm) begin
                     ok_in = 1'b1;
                     state_in = S_SCAN;
                  end
               default: ok_in = 1'b0;
            endcase
         end
         S_SCAN: begin
            // only find and sorted insert really scan; others fall through
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               if (op_ff == OP_FIND) begin
                  ok_in = stat.scan_hit;
                  state_in = S_COUNT;
                  cmd.set_found = stat.scan_hit;
               end else state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (op_ff == OP_READ) begin
               cmd.set_found = 1'b1;
               state_in = S_COUNT;
            end else if (stat.shift_done) state_in = is_ins ? S_WRITE : S_COUNT;
            else cmd.shift_step = 1'b1;
         end
         S_WRITE: begin
            cmd.write_new = 1'b1;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            if (ok_ff && op_ff <= OP_RM_AT) begin
               cmd.count_up = is_ins;
               cmd.count_down = !is_ins;
            end
            if (!ok_ff || op_ff <= OP_RM_AT) cmd.set_fail = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: state_in = S_DONE;
         S_DONE: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff <= ok_in;
      end
      if (cmd.load) op_ff <= req_operation;
   end
endmodule

FILE: hdl/sequential_array_list.sv
// top level of the sequential array list
// usage:
//  req_ channel carries one operation word (operation, position, key, payload)
//  rsp_ channel returns one result word per operation
//  one operation at a time; req_ready is high only when idle
//  steps per word: check, scan, shift, write (inserts only), count, result, done
//  rejected words go from check to count; find skips shift and write
//  only find and sorted insert scan the stored records; other operations do not
//  each move is a read phase then a write phase, due to the registered ram read
//  a new word is taken only after the previous result has been taken
//  reset clears the record count; record memory is not cleared
//  a stalled rsp_ holds the result and blocks new words
//  failed operations leave the list untouched
module sequential_array_list #(
   parameter int CAPACITY     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_operation,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_entry_key,
   input  logic [31:0]        req_entry_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_success,
   output logic signed [31:0] rsp_found_key,
   output logic [31:0]        rsp_found_payload,
   output logic [4:0]         rsp_found_position,
   output logic [5:0]         rsp_entry_count,
   output logic               rsp_is_full,
   output logic               rsp_is_empty
);
   import sal_pkg::*;
   sal_cmd_type cmd;
   sal_stat_type stat;
   logic ok;

   sal_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .stat(stat), .mode_ok(ok));

   sal_datapath #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_operation(req_operation), .req_position(req_position),
      .req_entry_key(req_entry_key), .req_entry_payload(req_entry_payload),
      .res_key(rsp_found_key),
      .res_payload(rsp_found_payload), .res_position(rsp_found_position),
      .res_count(rsp_entry_count), .res_full(rsp_is_full),
      .res_empty(rsp_is_empty));

   assign rsp_success = ok;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_full && rsp_is_empty)) else $error("full and empty");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

FILE: dv/sal_list_checker.sv
`timescale 1ns / 1ps
// checker: watches both channels, predicts list results and compares them
module sal_list_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [3:0]         req_operation,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_entry_key,
   input  logic [31:0]        req_entry_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_success,
   input  logic signed [31:0] rsp_found_key,
   input  logic [31:0]        rsp_found_payload,
   input  logic [4:0]         rsp_found_position,
   input  logic [5:0]         rsp_entry_count,
   input  logic               rsp_is_full,
   input  logic               rsp_is_empty,
   output int                 fail_count,
   output int                 pending_count,
   output int                 list_count
);
   import sal_pkg::*;
   localparam int CAP = 32;

   typedef struct packed {
      logic               success;
      logic signed [31:0] key;
      logic [31:0]        payload;
      logic [4:0]         position;
      logic [5:0]         count;
      logic               full;
      logic               empty;
   } list_result_type;

   logic signed [31:0] keys[CAP];
   logic [31:0]        pays[CAP];
   int                 count;
   list_result_type    expected_q[$];

   assign pending_count = expected_q.size();
   assign list_count    = count;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic bit insert_at(input int at, input logic signed [31:0] k,
                                    input logic [31:0] p);
      if (count >= CAP || at > count) return 0;
      for (int i = count; i > at; i--) begin
         keys[i] = keys[i-1];
         pays[i] = pays[i-1];
      end
      keys[at] = k;
      pays[at] = p;
      count++;
      return 1;
   endfunction

   function automatic bit remove_at(input int at);
      if (at >= count) return 0;
      for (int i = at; i + 1 < count; i++) begin
         keys[i] = keys[i+1];
         pays[i] = pays[i+1];
      end
      count--;
      return 1;
   endfunction

   function automatic list_result_type predict_list_op(input logic [3:0] op, input int pos,
                                                       input logic signed [31:0] k,
                                                       input logic [31:0] p);
      list_result_type r;
      int i;
      r = '0;
      case (op)
         OP_INS_FRONT: r.success = insert_at(0, k, p);
         OP_INS_END:   r.success = insert_at(count, k, p);
         OP_INS_SORT: begin
            for (i = 0; i < count; i++) if (keys[i] > k) break;
            r.success = insert_at(i, k, p);
         end
         OP_INS_AT:    r.success = insert_at(pos, k, p);
         OP_RM_FRONT:  r.success = remove_at(0);
         OP_RM_END:    r.success = (count != 0) ? remove_at(count - 1) : 1'b0;
         OP_RM_AT:     r.success = remove_at(pos);
         OP_FIND: begin
            for (i = 0; i < count; i++) begin
               if (keys[i] == k) begin
                  r.success  = 1;
                  r.key      = keys[i];
                  r.payload  = pays[i];
                  r.position = i[4:0];
                  break;
               end
            end
         end
         OP_READ: begin
            if (pos < count) begin
               r.success  = 1;
               r.key      = keys[pos];
               r.payload  = pays[pos];
               r.position = pos[4:0];
            end
         end
         default: ;
      endcase
      r.count = count[5:0];
      r.full  = (count == CAP);
      r.empty = (count == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type w;
      if (reset) begin
         count = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(predict_list_op(req_operation, req_position,
                                                  req_entry_key, req_entry_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected result word", 1, 0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_success !== w.success) report("success", rsp_success, w.success);
               if (rsp_found_key !== w.key) report("found_key", rsp_found_key, w.key);
               if (rsp_found_payload !== w.payload)
                  report("found_payload", rsp_found_payload, w.payload);
               if (rsp_found_position !== w.position)
                  report("found_position", rsp_found_position, w.position);
               if (rsp_entry_count !== w.count) report("entry_count", rsp_entry_count, w.count);
               if (rsp_is_full !== w.full) report("is_full", rsp_is_full, w.full);
               if (rsp_is_empty !== w.empty) report("is_empty", rsp_is_empty, w.empty);
            end
         end
      end
   end
endmodule

FILE: dv/tb_sequential_array_list.sv
`timescale 1ns / 1ps
// testbench top: drives list operations and gives the verdict
module tb_sequential_array_list;
   import sal_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [3:0]         req_operation = '0;
   logic [5:0]         req_position = '0;
   logic signed [31:0] req_entry_key = '0;
   logic [31:0]        req_entry_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic               rsp_success;
   logic signed [31:0] rsp_found_key;
   logic [31:0]        rsp_found_payload;
   logic [4:0]         rsp_found_position;
   logic [5:0]         rsp_entry_count;
   logic               rsp_is_full;
   logic               rsp_is_empty;
   int                 fail_count;
   int                 pending_count;
   int                 list_count;
   bit                 no_idle;

   always #2 clock = ~clock;

   sequential_array_list u_top (.*);

   sal_list_checker u_chk (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= no_idle || ($urandom_range(99) >= 25);
   end

   task automatic send_word(input logic [3:0] op, input logic [5:0] pos,
                            input logic [31:0] k, input logic [31:0] p);
      while (!no_idle && $urandom_range(99) < 25) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid         <= 1;
      req_operation     <= op;
      req_position      <= pos;
      req_entry_key     <= k;
      req_entry_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return 32'h8000_0000 | $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [3:0] op;
      logic [5:0] pos;
      int         bias;
      int         wait_cycles;
      no_idle = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty list failures, extremes, full list, bad codes
      send_word(OP_RM_FRONT, 0, 0, 0);
      send_word(OP_RM_END, 0, 0, 0);
      send_word(OP_FIND, 0, 0, 0);
      send_word(OP_READ, 0, 0, 0);
      send_word(OP_INS_SORT, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_INS_SORT, 0, 32'h8000_0000, 32'h0);
      send_word(OP_INS_SORT, 0, 32'h7FFF_FFFF, 32'h1234_5678);
      send_word(OP_INS_AT, 4, 5, 6);
      send_word(OP_INS_AT, 3, 5, 6);
      send_word(OP_FIND, 0, 32'h7FFF_FFFF, 0);
      send_word(OP_READ, 5, 0, 0);
      send_word(OP_RM_AT, 4, 0, 0);
      send_word(OP_RM_AT, 3, 0, 0);
      send_word(4'd9, 0, 0, 0);
      send_word(4'd15, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 32; i++) send_word(OP_INS_END, 0, i, ~i);
      send_word(OP_INS_FRONT, 0, 1, 1);
      send_word(OP_INS_AT, 0, 1, 1);
      send_word(OP_READ, 31, 0, 0);
      send_word(OP_READ, 32, 0, 0);
      send_word(OP_RM_AT, 32, 0, 0);
      send_word(OP_RM_AT, 31, 0, 0);
      send_word(OP_RM_FRONT, 0, 0, 0);
      send_word(OP_RM_END, 0, 0, 0);
      // random: drift toward inserts or removes so the list sweeps full and empty
      for (int n = 0; n < 2000; n++) begin
         if (n % 300 == 0) bias = $urandom_range(1) ? 70 : 30;
         no_idle = (n >= 800 && n < 1000);
         if ($urandom_range(99) < 5) op = 4'($urandom_range(15));
         else if ($urandom_range(99) < bias) op = 4'($urandom_range(3));
         else op = 4'($urandom_range(4, 8));
         if ($urandom_range(99) < 3) pos = 6'($urandom);
         else pos = 6'($urandom_range(list_count + 1));
         send_word(op, pos, pick_key(), $urandom);
      end
      req_valid <= 0;
      @(posedge clock);
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_sequential_array_list: done, clean");
      else
         $display("tb_sequential_array_list: done, errors");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_sequential_array_list: done, errors");
      $finish;
   end
endmodule
